// ===== design/aoc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alpha-over composite package
// Shared constants and the record that moves down the divider cell row.
// ----------------------------------------------------------------------------
package aoc_pkg;

	localparam int LANES   = 4;
	localparam int PIX_W   = 8;
	localparam int NUM_W   = 24;
	localparam int D_W     = 16;
	localparam int QBITS   = 8;
	localparam int LATENCY = 2 + QBITS;

	localparam logic [PIX_W-1:0] ALPHA_FULL = 8'd255;

	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;
	localparam int LANE_ALPHA = 3;

	typedef struct packed {
		logic                                valid;
		logic                                zero;
		logic [LANES-1:0][NUM_W-1:0]         rem;
		logic [LANES-1:0][NUM_W-1:0]         dvs;
		logic [LANES-1:0][QBITS-1:0]         quo;
	} cell_t;

endpackage

// ===== design/alpha_over_composite_unit.sv =====
// ----------------------------------------------------------------------------
// Alpha-over composite unit
// Porter-Duff over of two straight-alpha RGBA8 pixels, top over bottom.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge with start high and busy low. busy is
// always low: the unit takes one pixel pair every cycle.
// Each result appears on out_red, out_green, out_blue and out_alpha for one
// cycle with done high, after its request has passed the whole path: two multiply stages
// form the coverage D and the color numerators, then a row of 8 divider
// cells produces one quotient bit each, MSB first. Alpha is floor(D/255),
// taken through the same cells as a fourth lane.
// Throughput is one pixel per clock, set by the cell row moving every cycle.
// When both alphas are zero the result is all zeros.
// Reset clears the valid bits; requests in flight are dropped.
// The receiver cannot stall: results are not held beyond their cycle.
// ----------------------------------------------------------------------------
module alpha_over_composite_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  top_red,
	input  logic [7:0]  top_green,
	input  logic [7:0]  top_blue,
	input  logic [7:0]  top_alpha,
	input  logic [7:0]  bottom_red,
	input  logic [7:0]  bottom_green,
	input  logic [7:0]  bottom_blue,
	input  logic [7:0]  bottom_alpha,
	output logic        done,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha
);

	aoc_pkg::cell_t chain [0:aoc_pkg::QBITS];
	aoc_pkg::cell_t tail;
	logic           take;

	assign busy = 1'b0;
	assign take = start && !busy;

	aoc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.top_red      (top_red),
		.top_green    (top_green),
		.top_blue     (top_blue),
		.top_alpha    (top_alpha),
		.bottom_red   (bottom_red),
		.bottom_green (bottom_green),
		.bottom_blue  (bottom_blue),
		.bottom_alpha (bottom_alpha),
		.head         (chain[0])
	);

	for (genvar k = 0; k < aoc_pkg::QBITS; k++) begin : g_cell
		aoc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (chain[k]),
			.next   (chain[k+1])
		);
	end

	assign tail      = chain[aoc_pkg::QBITS];
	assign done      = tail.valid;
	assign out_red   = tail.zero ? 8'd0 : tail.quo[aoc_pkg::LANE_RED];
	assign out_green = tail.zero ? 8'd0 : tail.quo[aoc_pkg::LANE_GREEN];
	assign out_blue  = tail.zero ? 8'd0 : tail.quo[aoc_pkg::LANE_BLUE];
	assign out_alpha = tail.zero ? 8'd0 : tail.quo[aoc_pkg::LANE_ALPHA];

	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##(aoc_pkg::LATENCY) done)
		else $error("request did not complete in fixed latency");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, aoc_pkg::LATENCY))
		else $error("result without matching request");

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(done && tail.zero) |-> (out_alpha == 8'd0 && out_red == 8'd0))
		else $error("zero coverage gave nonzero result");

	a_alpha_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tail.zero) |-> (tail.quo[aoc_pkg::LANE_ALPHA] != 8'd0))
		else $error("nonzero coverage gave zero alpha");

	a_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !tail.zero) |->
		(tail.rem[aoc_pkg::LANE_ALPHA] < 24'(aoc_pkg::ALPHA_FULL)))
		else $error("alpha remainder not below divisor");

endmodule

// ===== design/aoc_front.sv =====
// ----------------------------------------------------------------------------
// Alpha-over front end
// Two multiply stages: form the coverage D and the three color numerators,
// then load the first divider cell record.
// ----------------------------------------------------------------------------
module aoc_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    take,
	input  logic [7:0]              top_red,
	input  logic [7:0]              top_green,
	input  logic [7:0]              top_blue,
	input  logic [7:0]              top_alpha,
	input  logic [7:0]              bottom_red,
	input  logic [7:0]              bottom_green,
	input  logic [7:0]              bottom_blue,
	input  logic [7:0]              bottom_alpha,
	output aoc_pkg::cell_t          head
);

	logic                   valid_s1;
	logic [2:0][15:0]       pt_s1;
	logic [2:0][15:0]       pb_s1;
	logic [15:0]            bw_s1;
	logic [7:0]             ta_s1;
	logic [7:0]             wa_s1;
	logic [7:0]             wa;
	logic [2:0][7:0]        ct;
	logic [2:0][7:0]        cb;
	logic [15:0]            d;
	logic [2:0][23:0]       num;
	logic                                            valid_s2;
	logic                                            zero_s2;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::NUM_W-1:0]   rem_s2;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::NUM_W-1:0]   dvs_s2;

	assign wa = aoc_pkg::ALPHA_FULL - top_alpha;
	assign ct = {top_blue, top_green, top_red};
	assign cb = {bottom_blue, bottom_green, bottom_red};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pt_s1[i] <= 16'(ct[i]) * 16'(top_alpha);
			pb_s1[i] <= 16'(cb[i]) * 16'(bottom_alpha);
		end
		bw_s1 <= 16'(bottom_alpha) * 16'(wa);
		ta_s1 <= top_alpha;
		wa_s1 <= wa;
	end

	assign d = 16'(ta_s1) * 16'(aoc_pkg::ALPHA_FULL) + bw_s1;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = ({pt_s1[i], 8'b0} - 24'(pt_s1[i])) + 24'(pb_s1[i]) * 24'(wa_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		zero_s2 <= (d == '0);
		for (int i = 0; i < 3; i++) begin
			rem_s2[i] <= num[i];
			dvs_s2[i] <= {1'b0, d, 7'b0};
		end
		rem_s2[aoc_pkg::LANE_ALPHA] <= 24'(d);
		dvs_s2[aoc_pkg::LANE_ALPHA] <= {9'b0, aoc_pkg::ALPHA_FULL, 7'b0};
	end

	assign head = '{valid: valid_s2, zero: zero_s2, rem: rem_s2, dvs: dvs_s2, quo: '0};

endmodule

// ===== design/aoc_div_cell.sv =====
// ----------------------------------------------------------------------------
// Alpha-over divider cell
// One restoring step per lane: compare, subtract, shift in a quotient bit,
// halve the divisor and hand the record to the next cell.
// ----------------------------------------------------------------------------
module aoc_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  aoc_pkg::cell_t  prev,
	output aoc_pkg::cell_t  next
);

	logic [aoc_pkg::LANES-1:0]                       ge;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::NUM_W-1:0]   rem_n;
	logic                                            valid_q;
	logic                                            zero_q;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::NUM_W-1:0]   rem_q;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::NUM_W-1:0]   dvs_q;
	logic [aoc_pkg::LANES-1:0][aoc_pkg::QBITS-1:0]   quo_q;

	always_comb begin
		for (int i = 0; i < aoc_pkg::LANES; i++) begin
			ge[i]    = (prev.rem[i] >= prev.dvs[i]);
			rem_n[i] = ge[i] ? (prev.rem[i] - prev.dvs[i]) : prev.rem[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	always_ff @(posedge clk) begin
		zero_q <= prev.zero;
		for (int i = 0; i < aoc_pkg::LANES; i++) begin
			rem_q[i] <= rem_n[i];
			dvs_q[i] <= prev.dvs[i] >> 1;
			quo_q[i] <= {prev.quo[i][aoc_pkg::QBITS-2:0], ge[i]};
		end
	end

	assign next = '{valid: valid_q, zero: zero_q, rem: rem_q, dvs: dvs_q, quo: quo_q};

endmodule
